>>> rtl/core/qdm_pkg.sv
// Shared types, widths and the saturating accumulate function for the quaternion MAC.
package qdm_pkg;

    localparam int COMP_W    = 16;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = 2 * COMP_W;
    localparam int TERM_W    = PROD_W + 2;
    localparam int NUM_LANES = 4;
    localparam int NUM_PROD  = NUM_LANES * NUM_LANES;

    localparam logic MODE_FWD  = 1'b0;
    localparam logic MODE_GRAD = 1'b1;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic conj;
    } stage_ctrl_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // One guard bit is enough: a lane term is always narrower than the sum.
    function automatic acc_t sat_add(acc_t a, term_t b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W+1-TERM_W){b[TERM_W-1]}}, b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

>>> rtl/core/qdm_mult.sv
// Input register and the sixteen registered component products.
module qdm_mult
    import qdm_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic                        in_last,
    input  logic                        conj_mode,
    input  comp_t [NUM_LANES-1:0]       x_in,
    input  comp_t [NUM_LANES-1:0]       k_in,
    output stage_ctrl_t                 prod_ctrl,
    output prod_t [NUM_PROD-1:0]        prod
);

    stage_ctrl_t          in_ctrl_reg;
    stage_ctrl_t          prod_ctrl_reg;
    comp_t [NUM_LANES-1:0] x_reg;
    comp_t [NUM_LANES-1:0] k_reg;
    prod_t [NUM_PROD-1:0]  prod_reg;
    prod_t [NUM_PROD-1:0]  prod_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ctrl_reg   <= '0;
            prod_ctrl_reg <= '0;
        end else if (ce) begin
            in_ctrl_reg.valid <= in_valid;
            in_ctrl_reg.last  <= in_last;
            in_ctrl_reg.conj  <= conj_mode;
            prod_ctrl_reg     <= in_ctrl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg    <= x_in;
            k_reg    <= k_in;
            prod_reg <= prod_next;
        end
    end

    // Entry a*4+b holds x[a]*k[b]; both modes draw on the same sixteen products.
    always_comb begin
        for (int a = 0; a < NUM_LANES; a++) begin
            for (int b = 0; b < NUM_LANES; b++) begin
                prod_next[a*NUM_LANES+b] = PROD_W'(x_reg[a]) * PROD_W'(k_reg[b]);
            end
        end
    end

    assign prod_ctrl = prod_ctrl_reg;
    assign prod      = prod_reg;

endmodule

>>> rtl/core/qdm_lanes.sv
// Signed four-way lane sums of the products, forward or conjugate sign pattern.
module qdm_lanes
    import qdm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     ce,
    input  stage_ctrl_t              prod_ctrl,
    input  prod_t [NUM_PROD-1:0]     prod,
    output stage_ctrl_t              term_ctrl,
    output term_t [NUM_LANES-1:0]    term
);

    stage_ctrl_t           term_ctrl_reg;
    term_t [NUM_LANES-1:0] term_reg;
    term_t [NUM_LANES-1:0] term_next;
    term_t [NUM_PROD-1:0]  pe;

    always_comb begin
        for (int n = 0; n < NUM_PROD; n++) begin
            pe[n] = {{(TERM_W-PROD_W){prod[n][PROD_W-1]}}, prod[n]};
        end
    end

    // pe[a*4+b] = x[a]*k[b]. The sums cannot overflow TERM_W, so order is free.
    always_comb begin
        if (prod_ctrl.conj == MODE_GRAD) begin
            term_next[0] = pe[0]  + pe[5]  + pe[10] + pe[15];
            term_next[1] = pe[4]  - pe[1]  + pe[14] - pe[11];
            term_next[2] = pe[8]  - pe[13] - pe[2]  + pe[7];
            term_next[3] = pe[12] + pe[9]  - pe[6]  - pe[3];
        end else begin
            term_next[0] = pe[0]  - pe[5]  - pe[10] - pe[15];
            term_next[1] = pe[1]  + pe[4]  + pe[11] - pe[14];
            term_next[2] = pe[2]  - pe[7]  + pe[8]  + pe[13];
            term_next[3] = pe[3]  + pe[6]  - pe[9]  + pe[12];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_ctrl_reg <= '0;
        end else if (ce) begin
            term_ctrl_reg <= prod_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            term_reg <= term_next;
        end
    end

    assign term_ctrl = term_ctrl_reg;
    assign term      = term_reg;

endmodule

>>> rtl/core/qdm_acc.sv
// Saturating running sums, result register and pipeline advance control.
module qdm_acc
    import qdm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  stage_ctrl_t              term_ctrl,
    input  term_t [NUM_LANES-1:0]    term,
    input  logic                     out_ready,
    output logic                     out_valid,
    output acc_t [NUM_LANES-1:0]     out_sum,
    output logic                     ce
);

    acc_t [NUM_LANES-1:0] sum_reg;
    acc_t [NUM_LANES-1:0] sum_next;
    acc_t [NUM_LANES-1:0] out_reg;
    logic                 out_valid_reg;
    logic                 emit;

    // Only a closing item must wait for the result register to empty.
    assign ce   = !(term_ctrl.valid && term_ctrl.last && out_valid_reg && !out_ready);
    assign emit = ce && term_ctrl.valid && term_ctrl.last;

    always_comb begin
        for (int n = 0; n < NUM_LANES; n++) begin
            sum_next[n] = sat_add(sum_reg[n], term[n]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ce && term_ctrl.valid) begin
                sum_reg <= term_ctrl.last ? '0 : sum_next;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= sum_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_reg;

endmodule

>>> rtl/core/quaternion_dense_mac.sv
// Top level of the streaming quaternion multiply-accumulate block.
//
//   Channel   Direction  Handshake               Payload
//   s_        in         s_tvalid / s_tready     s_tdata x and k quaternions, s_tlast last term
//   m_        out        m_tvalid / m_tready     m_tdata four saturated lane sums
//   cfg_      in         cfg_valid / cfg_ready   cfg_data conj_mode
//
// One item is taken per cycle while s_tready is high. Each item passes an input register,
// a product register and a lane-term register before it lands in the sums; the closing
// item's saturated total is written to the result register.
// Reset clears the sums, the result valid flag and conj_mode; cfg_ready is always high.
// s_tready drops only while a closing item waits for the result register to be taken.
module quaternion_dense_mac
    import qdm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // in_r, in_i, in_j, in_k, ker_r, ker_i, ker_j, ker_k (16 bits each)
    input  logic [8*COMP_W-1:0]       s_tdata,
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // out_r, out_i, out_j, out_k (48 bits each)
    output logic [NUM_LANES*ACC_W-1:0] m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data
);

    logic                  conj_mode_reg;
    logic                  ce;
    comp_t [NUM_LANES-1:0] x_in;
    comp_t [NUM_LANES-1:0] k_in;
    stage_ctrl_t           prod_ctrl;
    prod_t [NUM_PROD-1:0]  prod;
    stage_ctrl_t           term_ctrl;
    term_t [NUM_LANES-1:0] term;
    acc_t [NUM_LANES-1:0]  out_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conj_mode_reg <= MODE_FWD;
        end else if (cfg_valid && cfg_ready) begin
            conj_mode_reg <= cfg_data;
        end
    end

    assign x_in     = s_tdata[4*COMP_W-1:0];
    assign k_in     = s_tdata[8*COMP_W-1:4*COMP_W];
    assign s_tready = ce;
    assign m_tdata  = out_sum;

    qdm_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .conj_mode (conj_mode_reg),
        .x_in      (x_in),
        .k_in      (k_in),
        .prod_ctrl (prod_ctrl),
        .prod      (prod)
    );

    qdm_lanes u_lanes (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .prod_ctrl (prod_ctrl),
        .prod      (prod),
        .term_ctrl (term_ctrl),
        .term      (term)
    );

    qdm_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .term_ctrl (term_ctrl),
        .term      (term),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_sum   (out_sum),
        .ce        (ce)
    );

endmodule

>>> rtl/core/qdm_checker.sv
// Port-level checks of the quaternion MAC and their bind to the top level.
module qdm_checker
    import qdm_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [NUM_LANES*ACC_W-1:0] m_tdata,
    input logic                       cfg_ready
);

    // A result held back must stay put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // The input side may only stall behind a blocked result.
    a_in_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a blocked result");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind quaternion_dense_mac qdm_checker u_qdm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
